>>> src/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg: shared types and lookup functions for the escape sequence decoder
// Holds the decode mode codes, status codes, the result word layout and the
// small character tables for hex digits and escape letters.
// ----------------------------------------------------------------------------
`default_nettype none

package esd_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESCAPE = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_DROP   = 3'd4
   } esd_mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADESC = 2'd1,
      ST_BADHEX = 2'd2
   } esd_status_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [7:0]     out_byte;
      logic           has_byte;
      logic           out_last;
      esd_status_type status;
   } esd_word_type;

   // Hex digit lookup: valid flag plus digit value.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } esd_hex_type;

   // Escape letter lookup: valid flag plus control byte.
   typedef struct packed {
      logic       valid;
      logic [7:0] value;
   } esd_esc_type;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
   localparam logic [7:0] CASE_OFFSET    = 8'd32;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

   function automatic esd_hex_type hex_value(input logic [7:0] c);
      esd_hex_type r;
      logic [7:0]  d;
      r = '0;
      d = '0;
      if (c inside {["0":"9"]}) begin
         d = c - 8'h30;
         r = '{valid: 1'b1, value: d[3:0]};
      end else if (c inside {["a":"f"]}) begin
         d = c - 8'h61 + HEX_ALPHA_BASE;
         r = '{valid: 1'b1, value: d[3:0]};
      end else if (c inside {["A":"F"]}) begin
         d = c - 8'h41 + HEX_ALPHA_BASE;
         r = '{valid: 1'b1, value: d[3:0]};
      end
      return r;
   endfunction

   function automatic esd_esc_type escape_value(input logic [7:0] c);
      esd_esc_type r;
      logic [7:0]  l;
      l = (c inside {["A":"Z"]}) ? c + CASE_OFFSET : c;
      r = '{valid: 1'b1, value: 8'h00};
      case (l)
         8'h27:   r.value = 8'h27;   // single quote
         8'h22:   r.value = 8'h22;   // double quote
         8'h5C:   r.value = 8'h5C;   // backslash
         8'h30:   r.value = 8'h00;   // zero
         8'h61:   r.value = 8'h07;   // a
         8'h62:   r.value = 8'h08;   // b
         8'h66:   r.value = 8'h0C;   // f
         8'h6E:   r.value = 8'h0A;   // n
         8'h72:   r.value = 8'h0D;   // r
         8'h74:   r.value = 8'h09;   // t
         8'h76:   r.value = 8'h0B;   // v
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/esd_stream_if.sv
// ----------------------------------------------------------------------------
// esd_stream_if: valid/ready channels of the escape sequence decoder
// Request channel carries raw bytes, response channel carries decoded words.
// ----------------------------------------------------------------------------
`default_nettype none

interface esd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output has_byte, output out_last,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input out_last,
                   input status, output ready);
endinterface

`default_nettype wire

>>> src/escape_sequence_decoder_unit.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit: streaming C-style escape decoder
// Registered input word, single-pass decode, registered result word.
// ----------------------------------------------------------------------------
// The unit takes one raw byte per cycle while result words are taken and
// returns the decoded string, one word per produced byte; a byte passes the
// input register and its word the output register. Sustained rate is one
// byte per clock while words are taken: the only loop is the decode mode
// and high nibble register, updated as each byte advances, and the input
// and output registers let a new byte enter while a result waits on the
// response side. Bytes that open an escape (backslash, x, first hex digit)
// give no word. An error gives one word with has_byte low and out_last high;
// the rest of the string is dropped through its last byte, then the unit restarts.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_decoder_unit
   import esd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   esd_req_if.sink   req,
   esd_rsp_if.source rsp
);

   // Input register
   logic         req_valid_ff, req_valid_in;
   logic [7:0]   req_byte_ff;
   logic         req_last_ff;

   // Decode state
   esd_mode_type mode_ff, mode_in;
   logic [3:0]   nibble_ff, nibble_in;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   esd_word_type rsp_word_ff, rsp_word_in;

   logic         advance;
   logic         emit;
   esd_mode_type mode_next;
   logic [3:0]   nibble_next;
   esd_word_type word;

   // Advance the held byte when the output register is free or draining.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;

   esd_decode u_decode (
      .mode        (mode_ff),
      .nibble      (nibble_ff),
      .in_byte     (req_byte_ff),
      .in_last     (req_last_ff),
      .mode_next   (mode_next),
      .nibble_next (nibble_next),
      .emit        (emit),
      .word        (word)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req.valid && req.ready) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      nibble_in = nibble_ff;
      if (advance) begin
         mode_in   = mode_next;
         nibble_in = nibble_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance) begin
         rsp_valid_in = emit;
         rsp_word_in  = word;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         nibble_ff    <= 4'h0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         nibble_ff    <= nibble_in;
      end
   end

   // Payload: hold the incoming word on accept, the result on advance.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_byte_ff <= req.in_byte;
         req_last_ff <= req.in_last;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_word_ff.out_byte;
   assign rsp.has_byte = rsp_word_ff.has_byte;
   assign rsp.out_last = rsp_word_ff.out_last;
   assign rsp.status   = rsp_word_ff.status;

   // A held input word is never lost while it waits.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff)
      else $error("input word lost while stalled");

   // The high nibble is only live between the two hex digits.
   a_nibble_idle: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_HEX2 |-> nibble_ff == 4'h0)
      else $error("high nibble set outside hex escape");

   // The last byte of a dropped string returns the unit to normal.
   a_drop_exit: assert property (@(posedge clock) disable iff (reset)
      advance && mode_ff == MODE_DROP && req_last_ff |=> mode_ff == MODE_NORMAL)
      else $error("drop mode did not end on last byte");

   // An error word carries no byte and closes the string.
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status != ST_OK |->
         !rsp_word_ff.has_byte && rsp_word_ff.out_last && rsp_word_ff.out_byte == 8'h00)
      else $error("malformed error word");

endmodule

`default_nettype wire

>>> src/esd_decode.sv
// ----------------------------------------------------------------------------
// esd_decode: next-state and result logic of the escape decoder
// Takes the current mode, the held high nibble and one raw byte, and gives
// the next mode, next nibble and an optional result word.
// ----------------------------------------------------------------------------
`default_nettype none

module esd_decode
   import esd_pkg::*;
(
   input  esd_mode_type mode,
   input  logic [3:0]   nibble,
   input  logic [7:0]   in_byte,
   input  logic         in_last,
   output esd_mode_type mode_next,
   output logic [3:0]   nibble_next,
   output logic         emit,
   output esd_word_type word
);

   esd_hex_type hex;
   esd_esc_type esc;

   assign hex = hex_value(in_byte);
   assign esc = escape_value(in_byte);

   always_comb begin
      mode_next   = mode;
      nibble_next = nibble;
      emit        = 1'b0;
      word        = '{out_byte: 8'h00, has_byte: 1'b0, out_last: in_last, status: ST_OK};

      case (mode)
         MODE_ESCAPE: begin
            if (in_byte == CHAR_LOWER_X || in_byte == CHAR_UPPER_X) begin
               if (in_last) begin
                  emit        = 1'b1;
                  word.status = ST_BADHEX;
                  mode_next   = MODE_NORMAL;
                  nibble_next = 4'h0;
               end else begin
                  mode_next = MODE_HEX1;
               end
            end else if (!esc.valid) begin
               emit        = 1'b1;
               word.status = ST_BADESC;
               mode_next   = in_last ? MODE_NORMAL : MODE_DROP;
               nibble_next = 4'h0;
            end else begin
               emit          = 1'b1;
               word.out_byte = esc.value;
               word.has_byte = 1'b1;
               mode_next     = MODE_NORMAL;
            end
         end
         MODE_HEX1: begin
            if (!hex.valid || in_last) begin
               emit        = 1'b1;
               word.status = ST_BADHEX;
               mode_next   = in_last ? MODE_NORMAL : MODE_DROP;
               nibble_next = 4'h0;
            end else begin
               nibble_next = hex.value;
               mode_next   = MODE_HEX2;
            end
         end
         MODE_HEX2: begin
            emit        = 1'b1;
            nibble_next = 4'h0;
            if (!hex.valid) begin
               word.status = ST_BADHEX;
               mode_next   = in_last ? MODE_NORMAL : MODE_DROP;
            end else begin
               word.out_byte = {nibble, hex.value};
               word.has_byte = 1'b1;
               mode_next     = MODE_NORMAL;
            end
         end
         MODE_DROP: begin
            if (in_last) begin
               mode_next   = MODE_NORMAL;
               nibble_next = 4'h0;
            end
         end
         default: begin
            if (in_byte == CHAR_BACKSLASH) begin
               if (in_last) begin
                  emit        = 1'b1;
                  word.status = ST_BADESC;
                  mode_next   = MODE_NORMAL;
                  nibble_next = 4'h0;
               end else begin
                  mode_next = MODE_ESCAPE;
               end
            end else begin
               emit          = 1'b1;
               word.out_byte = in_byte;
               word.has_byte = 1'b1;
               mode_next     = MODE_NORMAL;
            end
         end
      endcase

      // Every error word closes the string.
      if (word.status != ST_OK) begin
         word.out_last = 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_esd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_esd_checker: decode predictor and word comparator
// Watches both channels, decodes each accepted request byte the way the unit
// should, queues the expected result words and compares every response word.
// ----------------------------------------------------------------------------

module tb_esd_checker
   import esd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   esd_req_if        req_ch,
   esd_rsp_if        rsp_ch,
   output int        fail_count,
   output int        pending_words,
   output int        checked_words,
   output int        error_words
);

   esd_mode_type scan_mode;
   logic [3:0]   first_digit;
   esd_word_type decoded_words[$];
   int           mismatches;
   int           matched;
   int           errors_seen;

   function automatic esd_hex_type digit_of(input logic [7:0] c);
      esd_hex_type h;
      logic [7:0]  d;
      h = '0;
      d = 8'h00;
      if (c >= "0" && c <= "9") begin
         d = c - "0";
         h.valid = 1'b1;
      end else if (c >= "a" && c <= "f") begin
         d = c - "a" + 8'd10;
         h.valid = 1'b1;
      end else if (c >= "A" && c <= "F") begin
         d = c - "A" + 8'd10;
         h.valid = 1'b1;
      end
      h.value = d[3:0];
      return h;
   endfunction

   function automatic esd_esc_type control_of(input logic [7:0] c);
      esd_esc_type e;
      logic [7:0]  folded;
      folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      e.valid = 1'b1;
      case (folded)
         "'":     e.value = 8'h27;
         "\"":    e.value = 8'h22;
         "\\":    e.value = 8'h5C;
         "0":     e.value = 8'h00;
         "a":     e.value = 8'h07;
         "b":     e.value = 8'h08;
         "f":     e.value = 8'h0C;
         "n":     e.value = 8'h0A;
         "r":     e.value = 8'h0D;
         "t":     e.value = 8'h09;
         "v":     e.value = 8'h0B;
         default: begin
            e.valid = 1'b0;
            e.value = 8'h00;
         end
      endcase
      return e;
   endfunction

   // Error word; drop the rest of the string unless this byte ends it.
   function automatic esd_word_type error_word(input logic last, input esd_status_type st);
      scan_mode   = last ? MODE_NORMAL : MODE_DROP;
      first_digit = 4'h0;
      return '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1, status: st};
   endfunction

   function automatic esd_word_type data_word(input logic [7:0] b, input logic last);
      return '{out_byte: b, has_byte: 1'b1, out_last: last, status: ST_OK};
   endfunction

   // Advance the decode state by one byte; return 1 when a word results.
   function automatic bit decode_byte(input logic [7:0] c, input logic last,
                                      output esd_word_type w);
      esd_hex_type h;
      esd_esc_type e;
      w = '0;
      case (scan_mode)
         MODE_ESCAPE: begin
            if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
               if (last) begin
                  w = error_word(last, ST_BADHEX);
                  return 1'b1;
               end
               scan_mode = MODE_HEX1;
               return 1'b0;
            end
            e = control_of(c);
            if (!e.valid) begin
               w = error_word(last, ST_BADESC);
               return 1'b1;
            end
            scan_mode = MODE_NORMAL;
            w = data_word(e.value, last);
            return 1'b1;
         end
         MODE_HEX1: begin
            h = digit_of(c);
            if (!h.valid || last) begin
               w = error_word(last, ST_BADHEX);
               return 1'b1;
            end
            first_digit = h.value;
            scan_mode   = MODE_HEX2;
            return 1'b0;
         end
         MODE_HEX2: begin
            h = digit_of(c);
            if (!h.valid) begin
               w = error_word(last, ST_BADHEX);
               return 1'b1;
            end
            scan_mode = MODE_NORMAL;
            w = data_word({first_digit, h.value}, last);
            first_digit = 4'h0;
            return 1'b1;
         end
         MODE_DROP: begin
            if (last) begin
               scan_mode   = MODE_NORMAL;
               first_digit = 4'h0;
            end
            return 1'b0;
         end
         default: begin
            if (c == CHAR_BACKSLASH) begin
               if (last) begin
                  w = error_word(last, ST_BADESC);
                  return 1'b1;
               end
               scan_mode = MODE_ESCAPE;
               return 1'b0;
            end
            scan_mode = MODE_NORMAL;
            w = data_word(c, last);
            return 1'b1;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      esd_word_type w;
      if (reset) begin
         scan_mode   = MODE_NORMAL;
         first_digit = 4'h0;
         decoded_words.delete();
         mismatches  = 0;
         matched     = 0;
         errors_seen = 0;
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            if (decode_byte(req_ch.in_byte, req_ch.in_last, w))
               decoded_words.push_back(w);
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (decoded_words.size() == 0) begin
               $error("unexpected result word: out_byte %0h has_byte %0b out_last %0b status %0d",
                      rsp_ch.out_byte, rsp_ch.has_byte, rsp_ch.out_last, rsp_ch.status);
               mismatches++;
            end else begin
               w = decoded_words.pop_front();
               matched++;
               if (!w.has_byte)
                  errors_seen++;
               if (rsp_ch.out_byte !== w.out_byte) begin
                  $error("out_byte mismatch: expected %0h, actual %0h",
                         w.out_byte, rsp_ch.out_byte);
                  mismatches++;
               end
               if (rsp_ch.has_byte !== w.has_byte) begin
                  $error("has_byte mismatch: expected %0b, actual %0b",
                         w.has_byte, rsp_ch.has_byte);
                  mismatches++;
               end
               if (rsp_ch.out_last !== w.out_last) begin
                  $error("out_last mismatch: expected %0b, actual %0b",
                         w.out_last, rsp_ch.out_last);
                  mismatches++;
               end
               if (rsp_ch.status !== w.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         w.status, rsp_ch.status);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_words <= decoded_words.size();
      checked_words <= matched;
      error_words   <= errors_seen;
   end

endmodule

>>> tb/sv/tb_escape_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder_unit: stimulus and verdict for the escape decoder
// Feeds directed and random escaped strings through the request channel under
// several idle and stall patterns; a side checker predicts and compares every
// result word, and this module reports the outcome.
// ----------------------------------------------------------------------------

module tb_escape_sequence_decoder_unit;
   import esd_pkg::*;

   localparam int IDLE_LIMIT   = 2000;   // cycles without any handshake
   localparam int DRAIN_CYCLES = 16;     // extra wait for stray result words
   localparam int PHASE_BYTES  = 440;    // random bytes per idling phase
   localparam int PHASES       = 4;

   logic clock;
   logic reset;

   esd_req_if req_if ();
   esd_rsp_if rsp_if ();

   int fail_count;
   int pending_words;
   int checked_words;
   int error_words;

   // Sender idle and receiver stall chances, in percent, for the active phase.
   int idle_pct;
   int stall_pct;
   int sent_bytes;
   int sent_strings;
   int quiet_cycles;

   logic [7:0] string_bytes[$];

   escape_sequence_decoder_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   tb_esd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .checked_words (checked_words),
      .error_words   (error_words)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: decide ready afresh every cycle from the current stall chance.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: give up when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                   (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("** escape_sequence_decoder_unit: FAILED **");
            $finish;
         end
      end
   end

   // Offer one byte, idling first at random, and hold it until accepted.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_byte(text[i], i == text.len() - 1);
      sent_strings++;
   endtask

   function automatic logic [7:0] hex_char(input int unsigned v);
      if (v < 10)
         return 8'("0" + v);
      return ($urandom_range(1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
   endfunction

   // Build one string out of plain bytes, escapes and hex pairs, with some
   // malformed escapes; now and then cut it short, then send it.
   task automatic send_random_string();
      string       letters;
      int          pieces;
      int          kind;
      int          keep;
      logic [7:0]  c;
      letters = "'\"\\0abfnrtv";
      pieces  = $urandom_range(1, 8);
      string_bytes.delete();
      repeat (pieces) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            string_bytes.push_back(8'($urandom_range(255)));
         end else if (kind < 65) begin
            c = letters[$urandom_range(letters.len() - 1)];
            if (c >= "a" && c <= "z" && $urandom_range(1) != 0)
               c = c - 8'd32;
            string_bytes.push_back(CHAR_BACKSLASH);
            string_bytes.push_back(c);
         end else if (kind < 85) begin
            string_bytes.push_back(CHAR_BACKSLASH);
            string_bytes.push_back($urandom_range(1) != 0 ? CHAR_LOWER_X : CHAR_UPPER_X);
            string_bytes.push_back(hex_char($urandom_range(15)));
            string_bytes.push_back(hex_char($urandom_range(15)));
         end else if (kind < 92) begin
            // Escape with an arbitrary byte; mostly not a known letter.
            string_bytes.push_back(CHAR_BACKSLASH);
            string_bytes.push_back(8'($urandom_range(255)));
         end else begin
            // Hex pair with a junk digit in either place.
            string_bytes.push_back(CHAR_BACKSLASH);
            string_bytes.push_back(CHAR_LOWER_X);
            if ($urandom_range(1) != 0) begin
               string_bytes.push_back(8'($urandom_range(255)));
            end else begin
               string_bytes.push_back(hex_char($urandom_range(15)));
               string_bytes.push_back(8'($urandom_range(255)));
            end
         end
      end
      if ($urandom_range(9) == 0) begin
         keep = $urandom_range(1, string_bytes.size());
         while (string_bytes.size() > keep)
            void'(string_bytes.pop_back());
      end
      foreach (string_bytes[i])
         send_byte(string_bytes[i], i == string_bytes.size() - 1);
      sent_strings++;
   endtask

   initial begin
      int phase_idle[PHASES];
      int phase_stall[PHASES];
      int phase_start;
      phase_idle  = '{0, 66, 0, 9};
      phase_stall = '{0, 0, 66, 9};
      idle_pct     = 0;
      stall_pct    = 0;
      sent_bytes   = 0;
      sent_strings = 0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.in_byte <= 8'h00;
      req_if.in_last <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings: byte extremes, upper-case hex, a bad first hex
      // digit with dropping, an unknown escape with dropping, a dangling
      // backslash, hex pairs cut short at the end, a bad second hex digit
      // on the last byte and an upper-case escape letter.
      send_byte(8'h00, 1'b1);
      sent_strings++;
      send_byte(8'hFF, 1'b1);
      sent_strings++;
      send_text("\\X7F");
      send_text("\\xgq");
      send_text("\\qA");
      send_text("\\");
      send_text("\\x");
      send_text("\\xA");
      send_text("\\xAZ");
      send_text("\\T");

      // Random strings, one batch per idling pattern.
      for (int p = 0; p < PHASES; p++) begin
         idle_pct    = phase_idle[p];
         stall_pct   = phase_stall[p];
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < PHASE_BYTES)
            send_random_string();
      end
      req_if.valid <= 1'b0;

      // Drain: wait for every expected word, then let stray words show up.
      stall_pct = 0;
      while (pending_words != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d strings over %0d idling patterns",
               sent_bytes, sent_strings, PHASES);
      $display("checked %0d result words, %0d of them error reports",
               checked_words, error_words);
      if (fail_count == 0) begin
         $display("** escape_sequence_decoder_unit: PASSED **");
      end else begin
         $display("** escape_sequence_decoder_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
src/esd_pkg.sv
src/esd_stream_if.sv
src/esd_decode.sv
src/escape_sequence_decoder_unit.sv
tb/sv/tb_esd_checker.sv
tb/sv/tb_escape_sequence_decoder_unit.sv
